// ===== design/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps

package rgbhsv_pkg;

  // Channel, result and configuration widths
  localparam int unsigned PixW   = 8;
  localparam int unsigned NumW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumStg = 7;
  localparam int unsigned NumDivStg = 4;
  localparam int unsigned BitsPerDivStg = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HUE_UPPER = 3'd0,
    CFG_SAT_UPPER = 3'd1,
    CFG_VAL_UPPER = 3'd2,
    CFG_HUE_LOWER = 3'd3,
    CFG_SAT_LOWER = 3'd4,
    CFG_VAL_LOWER = 3'd5
  } cfg_idx_e;

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_e;

  // Front stage: channels with their maximum, spread and winning channel
  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
    logic [PixW-1:0] mx;
    logic [PixW-1:0] d;
    max_sel_e        sel;
  } ext_t;

  // Divider stage: two restoring dividers running side by side
  typedef struct packed {
    logic [NumW-1:0] srem;
    logic [NumW-1:0] hrem;
    logic [PixW-1:0] sq;
    logic [PixW-1:0] hq;
    logic [PixW-1:0] sden;
    logic [PixW-1:0] hden;
    logic [PixW-1:0] val;
    logic            szero;
    logic            hzero;
  } div_t;

  // One restoring step at quotient bit k
  function automatic void div_bit(input logic [NumW-1:0] rem_in, input logic [PixW-1:0] den,
                                  input logic [2:0] k, output logic [NumW-1:0] rem_out,
                                  output logic qbit);
    logic [NumW-1:0] sh;
    sh = NumW'(den) << k;
    if (rem_in >= sh) begin
      rem_out = rem_in - sh;
      qbit    = 1'b1;
    end else begin
      rem_out = rem_in;
      qbit    = 1'b0;
    end
  endfunction

  // Two quotient bits, hi and hi-1, for both dividers
  function automatic div_t div_step(input div_t x, input logic [2:0] hi);
    div_t       y;
    logic [2:0] k;
    logic       qb;
    y = x;
    for (int unsigned s = 0; s < BitsPerDivStg; s++) begin
      k = hi - 3'(s);
      div_bit(y.srem, y.sden, k, y.srem, qb);
      y.sq[k] = qb;
      div_bit(y.hrem, y.hden, k, y.hrem, qb);
      y.hq[k] = qb;
    end
    return y;
  endfunction

  // Round to nearest, ties to even, given floor quotient and remainder < den
  function automatic logic [PixW-1:0] round_even(input logic [PixW-1:0] q,
                                                 input logic [NumW-1:0] rem,
                                                 input logic [PixW-1:0] den);
    logic [PixW:0] r2;
    logic [PixW:0] dn;
    r2 = {rem[PixW-1:0], 1'b0};
    dn = {1'b0, den};
    if (r2 > dn) begin
      return q + 8'd1;
    end else if (r2 == dn) begin
      return q + {7'd0, q[0]};
    end
    return q;
  endfunction

endpackage

// ===== design/rgb_to_hsv_range_mask.sv =====
`timescale 1ns / 1ps

// From input transfer to result, a pixel passes the extremes, dividend, divider and output registers.
// Throughput: one pixel per cycle while the output is not stalled; two restoring dividers, two quotient bits
// per stage over four stages, keep pace with the stream.
// Each stage holds its item until the next one can take it, so empty stages
// still fill while a result waits at the output.
// Reset clears all valid bits and sets all six bound registers to 0.
module rgb_to_hsv_range_mask
  import rgbhsv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Pixel input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
  // Result output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // hue_half[7:0], saturation[15:8], brightness[23:16]
  output logic                m_axis_tuser,   // in_range[0]
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [PixW-1:0]     cfg_data_i
);

  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] rdy;

  logic [PixW-1:0] hue_upper_q, sat_upper_q, val_upper_q;
  logic [PixW-1:0] hue_lower_q, sat_lower_q, val_lower_q;

  ext_t ext_d, ext_q;
  div_t div_q [NumDivStg+1];
  div_t num_d;

  logic [PixW-1:0] hue_d, sat_d, hue_q, sat_q, val_q;
  logic            ok_d, ok_q;

  // Bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_upper_q <= '0;
      sat_upper_q <= '0;
      val_upper_q <= '0;
      hue_lower_q <= '0;
      sat_lower_q <= '0;
      val_lower_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HUE_UPPER: hue_upper_q <= cfg_data_i;
        CFG_SAT_UPPER: sat_upper_q <= cfg_data_i;
        CFG_VAL_UPPER: val_upper_q <= cfg_data_i;
        CFG_HUE_LOWER: hue_lower_q <= cfg_data_i;
        CFG_SAT_LOWER: sat_lower_q <= cfg_data_i;
        CFG_VAL_LOWER: val_lower_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage takes a new item when empty or draining
  always_comb begin
    rdy[NumStg-1] = !v_q[NumStg-1] || m_axis_tready;
    for (int i = NumStg - 2; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign s_axis_tready = rdy[0];

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NumStg; i++) begin
        if (rdy[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // Stage 0: maximum, minimum, spread and winning channel
  always_comb begin
    logic [PixW-1:0] b, g, r, mx, mn;
    b  = s_axis_tdata[7:0];
    g  = s_axis_tdata[15:8];
    r  = s_axis_tdata[23:16];
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    ext_d.blue  = b;
    ext_d.green = g;
    ext_d.red   = r;
    ext_d.mx    = mx;
    ext_d.d     = mx - mn;
    if (r == mx) begin
      ext_d.sel = MAX_RED;
    end else if (g == mx) begin
      ext_d.sel = MAX_GREEN;
    end else begin
      ext_d.sel = MAX_BLUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ext_q <= ext_d;
    end
  end

  // Stage 1: dividends for saturation and hue
  always_comb begin
    logic signed [9:0]  diff;
    logic signed [17:0] n;
    logic signed [17:0] dd;
    dd = 18'(signed'({1'b0, ext_q.d}));
    case (ext_q.sel)
      MAX_RED: begin
        diff = 10'(signed'({1'b0, ext_q.green})) - 10'(signed'({1'b0, ext_q.blue}));
        n    = 18'(diff) * 18'sd30;
      end
      MAX_GREEN: begin
        diff = 10'(signed'({1'b0, ext_q.blue})) - 10'(signed'({1'b0, ext_q.red}));
        n    = 18'(diff) * 18'sd30 + dd * 18'sd60;
      end
      default: begin
        diff = 10'(signed'({1'b0, ext_q.red})) - 10'(signed'({1'b0, ext_q.green}));
        n    = 18'(diff) * 18'sd30 + dd * 18'sd120;
      end
    endcase
    // Wrap a negative hue by a full turn
    if (n < 0) begin
      n = n + dd * 18'sd180;
    end
    num_d.hrem  = n[NumW-1:0];
    num_d.srem  = {ext_q.d, 8'd0} - NumW'(ext_q.d);
    num_d.sq    = '0;
    num_d.hq    = '0;
    num_d.sden  = ext_q.mx;
    num_d.hden  = ext_q.d;
    num_d.val   = ext_q.mx;
    num_d.szero = (ext_q.mx == '0);
    num_d.hzero = (ext_q.d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      div_q[0] <= num_d;
    end
  end

  // Stages 2..5: two quotient bits each, most significant first
  for (genvar j = 0; j < NumDivStg; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (rdy[j+2]) begin
        div_q[j+1] <= div_step(div_q[j], 3'(PixW - 1 - BitsPerDivStg * j));
      end
    end
  end

  // Stage 6: rounding and range check
  always_comb begin
    div_t x;
    x     = div_q[NumDivStg];
    sat_d = x.szero ? '0 : round_even(x.sq, x.srem, x.sden);
    hue_d = x.hzero ? '0 : round_even(x.hq, x.hrem, x.hden);
    ok_d  = (hue_d <= hue_upper_q) && (hue_d >= hue_lower_q)
         && (sat_d <= sat_upper_q) && (sat_d >= sat_lower_q)
         && (x.val <= val_upper_q) && (x.val >= val_lower_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NumStg-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= div_q[NumDivStg].val;
      ok_q  <= ok_d;
    end
  end

  assign m_axis_tvalid = v_q[NumStg-1];
  assign m_axis_tdata  = {val_q, sat_q, hue_q};
  assign m_axis_tuser  = ok_q;

  // Hue never leaves the half-degree circle
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd180))
    else $error("hue out of range");

  // A black pixel has no saturation and no hue
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[23:16] == 8'd0) |->
      (m_axis_tdata[15:8] == 8'd0 && m_axis_tdata[7:0] == 8'd0))
    else $error("black pixel with color");

  // Zero saturation means a grey pixel, hence zero hue
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[15:8] == 8'd0) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("grey pixel with hue");

  // Input stalls only when the whole pipe is full behind a stalled output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&v_q)))
    else $error("input stalled with room in the pipe");

endmodule

// ===== verif/rgb_to_hsv_range_mask_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsv_range_mask_tb;
  import rgbhsv_pkg::*;

  localparam int IdlePct      = 18;
  localparam int RxHoldCycles = 200;
  localparam int SettleCycles = 12;
  localparam int StallLimit   = 2000;

  // Indexes past the last bound register; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } pixel_t;

  typedef struct {
    logic [PixW-1:0] hue_half;
    logic [PixW-1:0] saturation;
    logic [PixW-1:0] brightness;
    logic            in_range;
  } hsv_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // blue[7:0], green[15:8], red[23:16]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // hue_half[7:0], saturation[15:8], brightness[23:16]
  logic                m_axis_tuser;        // in_range[0]
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [PixW-1:0]     cfg_data_i = '0;

  // Shadow copy of the six bound registers, indexed by cfg_idx_e
  logic [PixW-1:0] bound_cfg [6] = '{default: '0};

  pixel_t pix_q[$];
  hsv_t   hsv_q[$];

  logic no_idle  = 1'b0;
  logic tx_pause = 1'b0;
  int   rx_hold_reqs = 0;
  int   rx_hold_seen = 0;
  int   rx_hold_left = 0;
  int   stall_cycles = 0;

  int n_pix_in     = 0;
  int n_hsv_out    = 0;
  int n_masked     = 0;
  int n_cfg_writes = 0;
  int n_settings   = 0;
  int n_err        = 0;

  rgb_to_hsv_range_mask u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Round num/den to nearest, ties to even
  function automatic int div_half_even(input int num, input int den);
    int q;
    int r;
    q = num / den;
    r = num % den;
    if (2 * r > den) begin
      q = q + 1;
    end else if (2 * r == den) begin
      q = q + (q & 1);
    end
    return q;
  endfunction

  // Expected hue, saturation, value and mask bit for one pixel
  function automatic hsv_t predict_hsv(input logic [PixW-1:0] blue,
                                       input logic [PixW-1:0] green,
                                       input logic [PixW-1:0] red);
    int   b;
    int   g;
    int   r;
    int   mx;
    int   mn;
    int   d;
    int   num;
    int   hue;
    int   sat;
    hsv_t res;
    b  = int'(blue);
    g  = int'(green);
    r  = int'(red);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    hue = 0;
    sat = 0;
    if (mx != 0) sat = div_half_even(255 * d, mx);
    if (d != 0) begin
      // Red wins ties over green, green over blue
      if (r == mx) begin
        num = 30 * (g - b);
      end else if (g == mx) begin
        num = 30 * (b - r) + 60 * d;
      end else begin
        num = 30 * (r - g) + 120 * d;
      end
      if (num < 0) num = num + 180 * d;
      hue = div_half_even(num, d);
    end
    res.hue_half   = PixW'(hue);
    res.saturation = PixW'(sat);
    res.brightness = PixW'(mx);
    res.in_range   = (hue <= bound_cfg[CFG_HUE_UPPER]) && (hue >= bound_cfg[CFG_HUE_LOWER])
                  && (sat <= bound_cfg[CFG_SAT_UPPER]) && (sat >= bound_cfg[CFG_SAT_LOWER])
                  && (mx  <= bound_cfg[CFG_VAL_UPPER]) && (mx  >= bound_cfg[CFG_VAL_LOWER]);
    return res;
  endfunction

  // Random pixel, biased toward greys, ties, extremes and the hue wrap
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     base;
    p.blue  = PixW'($urandom);
    p.green = PixW'($urandom);
    p.red   = PixW'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        p.green = p.blue;
        p.red   = p.blue;
      end
      1: begin
        base    = $urandom_range(2, 253);
        p.blue  = PixW'(base + $urandom_range(0, 2) - 1);
        p.green = PixW'(base + $urandom_range(0, 2) - 1);
        p.red   = PixW'(base + $urandom_range(0, 2) - 1);
      end
      2: begin
        p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      3: begin
        case ($urandom_range(0, 2))
          0:       p.green = p.red;
          1:       p.blue  = p.green;
          default: p.blue  = p.red;
        endcase
      end
      4: begin
        p.green = PixW'($urandom_range(0, 200));
        p.blue  = p.green + 8'd1;
        p.red   = PixW'($urandom_range(int'(p.blue) + 1, 255));
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic queue_rgb(input int red, input int green, input int blue);
    pix_q.push_back('{blue: PixW'(blue), green: PixW'(green), red: PixW'(red)});
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) pix_q.push_back(rand_pixel());
  endtask

  // One register write; the shadow copy follows once the write edge has passed
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [PixW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= CFG_VAL_LOWER) bound_cfg[idx] = data;
    n_cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic set_bounds(input int hue_hi, input int sat_hi, input int val_hi,
                            input int hue_lo, input int sat_lo, input int val_lo);
    cfg_write(CFG_HUE_UPPER, PixW'(hue_hi));
    cfg_write(CFG_SAT_UPPER, PixW'(sat_hi));
    cfg_write(CFG_VAL_UPPER, PixW'(val_hi));
    cfg_write(CFG_HUE_LOWER, PixW'(hue_lo));
    cfg_write(CFG_SAT_LOWER, PixW'(sat_lo));
    cfg_write(CFG_VAL_LOWER, PixW'(val_lo));
    n_settings++;
  endtask

  // Wait until every pixel is sent and every result is back, then let the pipe settle
  task automatic wait_drained();
    while (pix_q.size() != 0 || s_axis_tvalid || hsv_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic report_field(input string field, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
      n_err++;
    end
  endtask

  // Pixel driver: record the expectation on each transfer, then offer the next pixel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        hsv_q.push_back(predict_hsv(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]));
        n_pix_in++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the offered pixel
      end else if (!tx_pause && pix_q.size() != 0
                   && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix_q[0].red, pix_q[0].green, pix_q[0].blue};
        void'(pix_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: check each transfer against the oldest expectation, pace tready
  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_hsv_out++;
        if (m_axis_tuser) n_masked++;
        if (hsv_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h / %b", $time,
                   m_axis_tdata, m_axis_tuser);
          n_err++;
        end else begin
          want = hsv_q.pop_front();
          report_field("hue_half", want.hue_half, m_axis_tdata[7:0]);
          report_field("saturation", want.saturation, m_axis_tdata[15:8]);
          report_field("brightness", want.brightness, m_axis_tdata[23:16]);
          report_field("in_range", want.in_range, m_axis_tuser);
        end
      end
      if (rx_hold_left != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left  <= rx_hold_left - 1;
      end else if (rx_hold_reqs != rx_hold_seen) begin
        m_axis_tready <= 1'b0;
        rx_hold_seen  <= rx_hold_reqs;
        rx_hold_left  <= RxHoldCycles;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("** rgb_to_hsv_range_mask: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int h_a;
    int h_b;
    int s_a;
    int s_b;
    int v_a;
    int v_b;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed pixels under the reset bounds: only black passes the mask
    queue_rgb(0, 0, 0);
    queue_rgb(255, 255, 255);
    queue_rgb(77, 77, 77);
    queue_rgb(255, 0, 0);
    queue_rgb(0, 255, 0);
    queue_rgb(0, 0, 255);
    queue_rgb(255, 255, 0);
    queue_rgb(0, 255, 255);
    queue_rgb(255, 0, 255);
    queue_rgb(255, 0, 1);     // hue rounds up to a full turn
    queue_rgb(200, 10, 12);   // likewise
    queue_rgb(2, 1, 1);       // saturation lands on a half
    queue_rgb(5, 2, 1);       // hue lands on a half
    queue_rgb(200, 50, 100);  // red max, negative hue before wrap
    queue_rgb(30, 200, 100);
    queue_rgb(100, 30, 200);
    queue_rgb(1, 0, 0);
    queue_rgb(254, 255, 253);
    queue_rgb(128, 127, 129);
    queue_rgb(0, 1, 0);
    wait_drained();

    // Wide-open window with hue bound above 180; stall the output for a long stretch
    set_bounds(255, 255, 255, 0, 0, 0);
    @(posedge clk_i);
    no_idle      <= 1'b1;
    rx_hold_reqs <= rx_hold_reqs + 1;
    @(negedge clk_i);
    queue_random(80);
    wait_drained();
    @(posedge clk_i);
    no_idle <= 1'b0;

    // Mid-size window; spare indexes must not disturb it; pause the sender mid-run
    set_bounds(120, 200, 220, 20, 40, 30);
    cfg_write(CfgIdxSpareLo, 8'hFF);
    cfg_write(CfgIdxSpareHi, 8'h00);
    queue_random(80);
    while (pix_q.size() > 40) @(negedge clk_i);
    @(posedge clk_i);
    tx_pause <= 1'b1;
    @(negedge clk_i);
    while (s_axis_tvalid || hsv_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
    tx_pause <= 1'b0;
    @(negedge clk_i);
    wait_drained();

    // Lower bounds above upper bounds: nothing passes
    set_bounds(50, 100, 100, 100, 200, 200);
    queue_random(60);
    wait_drained();

    // Hue pinned at a full turn
    set_bounds(180, 255, 255, 180, 0, 0);
    queue_random(40);
    wait_drained();

    // Random windows, lower never above upper
    for (int w = 0; w < 4; w++) begin
      h_a = $urandom_range(0, 180);
      h_b = $urandom_range(0, 180);
      s_a = $urandom_range(0, 255);
      s_b = $urandom_range(0, 255);
      v_a = $urandom_range(0, 255);
      v_b = $urandom_range(0, 255);
      set_bounds((h_a > h_b) ? h_a : h_b, (s_a > s_b) ? s_a : s_b, (v_a > v_b) ? v_a : v_b,
                 (h_a > h_b) ? h_b : h_a, (s_a > s_b) ? s_b : s_a, (v_a > v_b) ? v_b : v_a);
      queue_random(60);
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    $display("Sent %0d pixels, checked %0d results (%0d inside the window) over %0d bound sets,",
             n_pix_in, n_hsv_out, n_masked, n_settings);
    $display("with %0d register writes, an output stall, a sender pause and random idling.",
             n_cfg_writes);
    if (n_err == 0 && hsv_q.size() == 0) begin
      $display("** rgb_to_hsv_range_mask: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results still expected", n_err, hsv_q.size());
      $display("** rgb_to_hsv_range_mask: FAILED **");
    end
    $finish;
  end

endmodule
